// ----- hdl/ascon_pkg.sv -----
// Package: Ascon engine types, constants and round function.
package ascon_pkg;
	localparam logic [63:0] ASCON_IV = 64'h80400c0600000000;
	localparam logic [63:0] PAD0 = 64'h8000000000000000;
	// round index marker: block data still waits to be absorbed
	localparam logic [3:0] RND_ABSORB = 4'd15;

	typedef enum logic [2:0] {
		CMD_INIT = 3'd0, CMD_AD_BLK = 3'd1, CMD_AD_FIN = 3'd2, CMD_ENC_BLK = 3'd3,
		CMD_ENC_FIN = 3'd4, CMD_DEC_BLK = 3'd5, CMD_DEC_FIN = 3'd6, CMD_BAD = 3'd7
	} cmd_t;

	typedef enum logic [1:0] {
		PH_IDLE = 2'd0, PH_START = 2'd1, PH_AD = 2'd2, PH_CLOSED = 2'd3
	} phase_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_CLOSE, ST_BODY, ST_FIN, ST_DONE
	} seq_t;

	typedef logic [4:0][63:0] sponge_t;

	function automatic logic [63:0] rotr(input logic [63:0] v, input int n);
		rotr = (v >> n) | (v << (64 - n));
	endfunction

	function automatic logic [7:0] rc(input logic [3:0] i);
		logic [7:0] r;
		r = 8'h00;
		case (i)
			4'd0: r = 8'hf0; 4'd1: r = 8'he1; 4'd2: r = 8'hd2; 4'd3: r = 8'hc3;
			4'd4: r = 8'hb4; 4'd5: r = 8'ha5; 4'd6: r = 8'h96; 4'd7: r = 8'h87;
			4'd8: r = 8'h78; 4'd9: r = 8'h69; 4'd10: r = 8'h5a; 4'd11: r = 8'h4b;
			default: r = 8'h00;
		endcase
		return r;
	endfunction

	function automatic logic [63:0] lead_mask(input logic [2:0] n);
		lead_mask = (n == 3'd0) ? 64'd0 : ~(64'hffffffffffffffff >> {n, 3'b000});
	endfunction

	function automatic logic [63:0] pad_bit(input logic [2:0] n);
		pad_bit = PAD0 >> {n, 3'b000};
	endfunction
endpackage

// ----- hdl/ascon_round.sv -----
// One Ascon permutation round, shared by every phase of the engine.
module ascon_round (
	input  ascon_pkg::sponge_t s_in,
	input  logic [3:0]         rnd,
	output ascon_pkg::sponge_t s_out
);
	import ascon_pkg::*;
	logic [63:0] a, b, d, e, f, t0, t1, t2, t3, t4;
	logic [63:0] a2, b2, d2, e2, f2;
	always_comb begin
		a = s_in[0] ^ s_in[4];
		f = s_in[4] ^ s_in[3];
		e = s_in[3];
		b = s_in[1];
		d = s_in[2] ^ {56'd0, rc(rnd)} ^ s_in[1];
		t0 = ~a & b; t1 = ~b & d; t2 = ~d & e; t3 = ~e & f; t4 = ~f & a;
		a2 = a ^ t1; b2 = b ^ t2; d2 = d ^ t3; e2 = e ^ t4; f2 = f ^ t0;
		b2 = b2 ^ a2; a2 = a2 ^ f2; e2 = e2 ^ d2; d2 = ~d2;
		s_out[0] = a2 ^ rotr(a2, 19) ^ rotr(a2, 28);
		s_out[1] = b2 ^ rotr(b2, 61) ^ rotr(b2, 39);
		s_out[2] = d2 ^ rotr(d2, 1) ^ rotr(d2, 6);
		s_out[3] = e2 ^ rotr(e2, 10) ^ rotr(e2, 17);
		s_out[4] = f2 ^ rotr(f2, 7) ^ rotr(f2, 41);
	end
endmodule

// ----- hdl/ascon128_aead_engine_core.sv -----
// Top level: Ascon-128 AEAD engine with a shared round unit and sequencer.
// Usage:
//  s_axis carries one command beat: tuser = command, tdata packs
//  data_word, byte_count, nonce_hi, nonce_lo, tag_in_hi, tag_in_lo.
//  m_axis returns one result beat per command: tdata packs out_word,
//  out_count, tag_out_hi, tag_out_lo, tag_ok; tuser = status.
//  Key registers are written through cfg_we/cfg_idx/cfg_data while idle.
// Timing: one Ascon round per cycle in a single shared round unit. Steps
//  from the accepted command until the result beat is offered:
//  out-of-order: result only; init: 12 rounds, then result; AD block and
//  AD final: 6 rounds, then result, or result only for an empty AD final
//  right after init; enc/dec block: absorb, 6 rounds, result; enc/dec
//  final: absorb and key, 12 rounds, result. Add 6 close rounds to an
//  enc/dec command that follows nonempty AD. The next command is accepted
//  only after the result beat has been taken by the receiver.
// Ready: s_axis_tready is high only when no command is in work and the
//  result register is empty; a stalled receiver holds the result beat
//  and blocks the next command.
// Reset: sponge cleared, phase idle, keys zero, output empty.
module ascon128_aead_engine_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_we,
	input  logic         cfg_idx,
	input  logic [63:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: data_word[63:0], byte_count[66:64], nonce_hi[130:67],
	// nonce_lo[194:131], tag_in_hi[258:195], tag_in_lo[322:259], zero pad
	input  logic [327:0] s_axis_tdata,
	input  logic [2:0]   s_axis_tuser,  // command
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: out_word[63:0], out_count[67:64], tag_out_hi[131:68],
	// tag_out_lo[195:132], tag_ok[196], zero pad
	output logic [199:0] m_axis_tdata,
	output logic         m_axis_tuser   // status
);
	import ascon_pkg::*;

	seq_t st_q, st_d;
	sponge_t sp_q, rnd_out;
	phase_t ph_q;
	logic [63:0] key_hi_q, key_lo_q;
	logic [3:0] rnd_q;
	logic [2:0] cmd_q, n_q;
	logic [63:0] data_q, thi_q, tlo_q, ow_q;
	logic ovalid_q;
	logic [199:0] odata_q;
	logic ostat_q;

	ascon_round u_round (.s_in(sp_q), .rnd(rnd_q), .s_out(rnd_out));

	assign s_axis_tready = (st_q == ST_IDLE) && !ovalid_q;
	assign m_axis_tvalid = ovalid_q;
	assign m_axis_tdata = odata_q;
	assign m_axis_tuser = ostat_q;

	logic acc;
	logic [2:0] cmd_i, n_i;
	logic bad_i;
	assign acc = s_axis_tvalid && s_axis_tready;
	assign cmd_i = s_axis_tuser;
	assign n_i = s_axis_tdata[66:64];
	assign bad_i = (cmd_i == CMD_BAD) || (cmd_i != CMD_INIT && ph_q == PH_IDLE) ||
		((cmd_i == CMD_AD_BLK || cmd_i == CMD_AD_FIN) && ph_q == PH_CLOSED);

	logic last_rnd;
	assign last_rnd = (rnd_q == 4'd11);
	logic is_fin;
	assign is_fin = (cmd_q == CMD_ENC_FIN) || (cmd_q == CMD_DEC_FIN);

	// next state
	always_comb begin
		st_d = st_q;
		unique case (st_q)
			ST_IDLE: if (acc && !bad_i) begin
				unique case (cmd_i)
					CMD_INIT, CMD_AD_BLK: st_d = ST_BODY;
					CMD_AD_FIN: st_d = (n_i != 3'd0 || ph_q == PH_AD) ? ST_BODY : ST_DONE;
					default: st_d = (ph_q == PH_AD) ? ST_CLOSE : ST_BODY;
				endcase
			end
			ST_CLOSE: if (last_rnd) st_d = ST_BODY;
			ST_BODY: if (is_fin) st_d = ST_FIN;
				else if (last_rnd) st_d = ST_DONE;
			ST_FIN: if (last_rnd) st_d = ST_DONE;
			ST_DONE: st_d = ST_IDLE;
			default: st_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= ST_IDLE;
			ph_q <= PH_IDLE;
			sp_q <= '0;
			rnd_q <= '0;
			key_hi_q <= '0;
			key_lo_q <= '0;
			ovalid_q <= 1'b0;
			cmd_q <= '0;
			n_q <= '0;
			data_q <= '0;
			thi_q <= '0;
			tlo_q <= '0;
			ow_q <= '0;
			odata_q <= '0;
			ostat_q <= 1'b0;
		end else begin
			st_q <= st_d;
			if (cfg_we) begin
				if (cfg_idx) key_lo_q <= cfg_data;
				else key_hi_q <= cfg_data;
			end
			if (ovalid_q && m_axis_tready) ovalid_q <= 1'b0;
			unique case (st_q)
				ST_IDLE: if (acc) begin
					cmd_q <= cmd_i;
					n_q <= n_i;
					data_q <= s_axis_tdata[63:0];
					thi_q <= s_axis_tdata[258:195];
					tlo_q <= s_axis_tdata[322:259];
					ow_q <= '0;
					if (bad_i) begin
						ovalid_q <= 1'b1;
						ostat_q <= 1'b1;
						odata_q <= '0;
					end else begin
						unique case (cmd_i)
							CMD_INIT: begin
								sp_q <= {s_axis_tdata[194:131], s_axis_tdata[130:67],
									key_lo_q, key_hi_q, ASCON_IV};
								rnd_q <= 4'd0;
								ph_q <= PH_START;
							end
							CMD_AD_BLK: begin
								sp_q[0] <= sp_q[0] ^ s_axis_tdata[63:0];
								rnd_q <= 4'd6;
								ph_q <= PH_AD;
							end
							CMD_AD_FIN: begin
								if (n_i != 3'd0 || ph_q == PH_AD)
									sp_q[0] <= sp_q[0] ^ (s_axis_tdata[63:0] & lead_mask(n_i))
										^ pad_bit(n_i);
								else
									sp_q[4] <= sp_q[4] ^ 64'd1;
								rnd_q <= 4'd6;
								ph_q <= PH_CLOSED;
							end
							default: begin
								if (ph_q == PH_AD) begin
									sp_q[0] <= sp_q[0] ^ PAD0;
									rnd_q <= 4'd6;
								end else begin
									if (ph_q == PH_START) sp_q[4] <= sp_q[4] ^ 64'd1;
									rnd_q <= RND_ABSORB;
								end
								ph_q <= PH_CLOSED;
							end
						endcase
					end
				end
				ST_CLOSE: begin
					sp_q <= rnd_out;
					rnd_q <= rnd_q + 4'd1;
					if (last_rnd) begin
						sp_q[4] <= rnd_out[4] ^ 64'd1;
						rnd_q <= RND_ABSORB;
					end
				end
				ST_BODY: begin
					if (cmd_q == CMD_INIT || cmd_q == CMD_AD_BLK || cmd_q == CMD_AD_FIN) begin
						sp_q <= rnd_out;
						rnd_q <= rnd_q + 4'd1;
						if (last_rnd && cmd_q == CMD_INIT) begin
							sp_q[3] <= rnd_out[3] ^ key_hi_q;
							sp_q[4] <= rnd_out[4] ^ key_lo_q;
						end
						if (last_rnd && cmd_q == CMD_AD_FIN)
							sp_q[4] <= rnd_out[4] ^ 64'd1;
					end else if (cmd_q == CMD_ENC_BLK || cmd_q == CMD_DEC_BLK) begin
						if (rnd_q == RND_ABSORB) begin
							// absorb data and emit output before the rounds
							ow_q <= sp_q[0] ^ data_q;
							if (cmd_q == CMD_ENC_BLK) sp_q[0] <= sp_q[0] ^ data_q;
							else sp_q[0] <= data_q;
							rnd_q <= 4'd6;
						end else begin
							sp_q <= rnd_out;
							rnd_q <= rnd_q + 4'd1;
						end
					end else begin
						ow_q <= (sp_q[0] ^ data_q) & lead_mask(n_q);
						if (cmd_q == CMD_ENC_FIN)
							sp_q[0] <= sp_q[0] ^ (data_q & lead_mask(n_q)) ^ pad_bit(n_q);
						else
							sp_q[0] <= ((sp_q[0] & ~lead_mask(n_q)) | (data_q & lead_mask(n_q)))
								^ pad_bit(n_q);
						sp_q[1] <= sp_q[1] ^ key_hi_q;
						sp_q[2] <= sp_q[2] ^ key_lo_q;
						rnd_q <= 4'd0;
					end
				end
				ST_FIN: begin
					sp_q <= rnd_out;
					rnd_q <= rnd_q + 4'd1;
				end
				ST_DONE: begin
					ovalid_q <= 1'b1;
					ostat_q <= 1'b0;
					odata_q <= '0;
					odata_q[63:0] <= ow_q;
					if (cmd_q == CMD_ENC_BLK || cmd_q == CMD_DEC_BLK)
						odata_q[67:64] <= 4'd8;
					if (is_fin) begin
						odata_q[67:64] <= {1'b0, n_q};
						odata_q[131:68] <= sp_q[3] ^ key_hi_q;
						odata_q[195:132] <= sp_q[4] ^ key_lo_q;
						odata_q[196] <= (cmd_q == CMD_DEC_FIN) &&
							((sp_q[3] ^ key_hi_q) == thi_q) && ((sp_q[4] ^ key_lo_q) == tlo_q);
						sp_q <= '0;
						ph_q <= PH_IDLE;
					end
				end
				default: ;
			endcase
		end
	end
endmodule

// ----- hdl/ascon_checker.sv -----
// Port checker for the Ascon engine, bound to the top level.
module ascon_checker (
	input logic         clk,
	input logic         arst_n,
	input logic         s_axis_tvalid,
	input logic         s_axis_tready,
	input logic         m_axis_tvalid,
	input logic         m_axis_tready,
	input logic [199:0] m_axis_tdata,
	input logic         m_axis_tuser
);
	a_no_in_while_out: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid |-> !s_axis_tready) else $error("ready while result pending");
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
		else $error("result dropped");
	a_bad_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |-> m_axis_tdata == '0) else $error("error beat not zero");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready) else $error("ready after accept");
endmodule

bind ascon128_aead_engine_core ascon_checker u_chk (.*);
